@@ hdl/mbbs_pkg.sv @@
package mbbs_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int COORD_WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] pos_x;
      logic signed [FIELD_WIDTH-1:0] pos_y;
      logic signed [FIELD_WIDTH-1:0] pos_z;
      logic                          last_vertex;
   } vertex_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] min_x;
      logic signed [FIELD_WIDTH-1:0] min_y;
      logic signed [FIELD_WIDTH-1:0] min_z;
      logic signed [FIELD_WIDTH-1:0] max_x;
      logic signed [FIELD_WIDTH-1:0] max_y;
      logic signed [FIELD_WIDTH-1:0] max_z;
      logic signed [FIELD_WIDTH-1:0] centre_x;
      logic signed [FIELD_WIDTH-1:0] centre_y;
      logic signed [FIELD_WIDTH-1:0] centre_z;
      logic        [FIELD_WIDTH-1:0] radius;
   } result_type;

   typedef struct packed {
      logic take;
      logic seed;
   } lane_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } root_status_type;

endpackage

@@ hdl/mbbs_if.sv @@
interface mbbs_req_if;
   logic                 valid;
   logic                 ready;
   mbbs_pkg::vertex_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mbbs_rsp_if;
   logic                 valid;
   logic                 ready;
   mbbs_pkg::result_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/mbbs_lane.sv @@
module mbbs_lane #(
   parameter int COORD_WIDTH = mbbs_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  mbbs_pkg::lane_ctrl_type       ctrl,
   input  logic signed [COORD_WIDTH-1:0] coord,
   output logic signed [COORD_WIDTH-1:0] box_min,
   output logic signed [COORD_WIDTH-1:0] box_max,
   output logic signed [COORD_WIDTH-1:0] centre,
   output logic [2*COORD_WIDTH-1:0]      square
);

   logic signed [COORD_WIDTH-1:0] min_ff, min_in;
   logic signed [COORD_WIDTH-1:0] max_ff, max_in;
   logic        [COORD_WIDTH-1:0] ext_ff, ext_in;
   logic signed [COORD_WIDTH-1:0] centre_ff, centre_in;
   logic [2*COORD_WIDTH-1:0]      sq_ff, sq_in;
   logic signed [COORD_WIDTH:0]   mid_sum;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (ctrl.take) begin
         if (ctrl.seed || (coord < min_ff)) begin
            min_in = coord;
         end
         if (ctrl.seed || (coord > max_ff)) begin
            max_in = coord;
         end
      end
   end

   // extent never exceeds the unsigned coordinate range since max >= min
   assign ext_in    = COORD_WIDTH'(max_ff - min_ff);
   assign mid_sum   = (COORD_WIDTH+1)'(max_ff) + (COORD_WIDTH+1)'(min_ff);
   // arithmetic shift of the widened sum gives the floored midpoint
   assign centre_in = mid_sum[COORD_WIDTH:1];
   assign sq_in     = (2*COORD_WIDTH)'(ext_ff) * (2*COORD_WIDTH)'(ext_ff);

   always_ff @(posedge clock) begin
      min_ff    <= min_in;
      max_ff    <= max_in;
      ext_ff    <= ext_in;
      centre_ff <= centre_in;
      sq_ff     <= sq_in;
   end

   assign box_min = min_ff;
   assign box_max = max_ff;
   assign centre  = centre_ff;
   assign square  = sq_ff;

endmodule

@@ hdl/mbbs_merge.sv @@
module mbbs_merge #(
   parameter int COORD_WIDTH = mbbs_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2*COORD_WIDTH-1:0]      square_x,
   input  logic [2*COORD_WIDTH-1:0]      square_y,
   input  logic [2*COORD_WIDTH-1:0]      square_z,
   output mbbs_pkg::root_status_type     status,
   output logic [COORD_WIDTH-1:0]        radius
);

   localparam int CountWidth = $clog2(COORD_WIDTH + 1);

   logic [2*COORD_WIDTH+1:0] sum_all;
   logic [2*COORD_WIDTH-1:0] n_ff, n_in;
   logic [COORD_WIDTH:0]     rem_ff, rem_in;
   logic [COORD_WIDTH-1:0]   root_ff, root_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     running_ff, running_in;
   logic                     done_ff, done_in;
   logic [COORD_WIDTH+1:0]   rem_sh;
   logic [COORD_WIDTH+1:0]   trial;

   assign sum_all = (2*COORD_WIDTH+2)'(square_x) + (2*COORD_WIDTH+2)'(square_y)
                  + (2*COORD_WIDTH+2)'(square_z);

   // one root bit per cycle: bring down two radicand bits, try root*4+1
   assign rem_sh = {rem_ff[COORD_WIDTH-1:0], n_ff[2*COORD_WIDTH-1:2*COORD_WIDTH-2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      n_in       = n_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = done_ff;
      if (start) begin
         n_in       = sum_all[2*COORD_WIDTH+1:2];
         rem_in     = '0;
         root_in    = '0;
         count_in   = CountWidth'(COORD_WIDTH);
         running_in = 1'b1;
         done_in    = 1'b0;
      end else if (running_ff) begin
         n_in = {n_ff[2*COORD_WIDTH-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (COORD_WIDTH+1)'(rem_sh - trial);
            root_in = {root_ff[COORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[COORD_WIDTH:0];
            root_in = {root_ff[COORD_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - CountWidth'(1);
         if (count_ff == CountWidth'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      n_ff     <= n_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      count_ff <= count_in;
   end

   assign status.busy = running_ff;
   assign status.done = done_ff;
   assign radius      = root_ff;

endmodule

@@ hdl/mesh_bounding_box_sphere_unit.sv @@
// channel  dir  handshake            payload
// req_if   in   valid/ready          pos_x, pos_y, pos_z, last_vertex
// rsp_if   out  valid/ready          box corners, centre, radius
//
// vertices transfer one per cycle; three axis lanes track min/max in parallel
// a last vertex holds req ready low through extent, square, sum of squares and
// the root unit, which resolves one radius bit per cycle
// a result waiting in the output register does not block the next mesh, but a
// second mesh end waits until that register is free
// reset (synchronous) empties the output register and rearms the box seed
module mesh_bounding_box_sphere_unit #(
   parameter int COORD_WIDTH = mbbs_pkg::COORD_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mbbs_req_if.sink  req_if,
   mbbs_rsp_if.source rsp_if
);

   localparam int FW = mbbs_pkg::FIELD_WIDTH;

   typedef enum logic [2:0] {
      ST_STREAM,
      ST_EXTENT,
      ST_SQUARE,
      ST_START,
      ST_ROOT
   } state_type;

   state_type                 state_ff, state_in;
   logic                      first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mbbs_pkg::result_type      rsp_data_ff, rsp_data_in;

   logic                      take;
   logic                      out_free;
   logic                      load_out;
   logic                      root_start;
   mbbs_pkg::lane_ctrl_type   lane_ctrl;
   mbbs_pkg::root_status_type root_status;

   logic signed [COORD_WIDTH-1:0] min_x, min_y, min_z;
   logic signed [COORD_WIDTH-1:0] max_x, max_y, max_z;
   logic signed [COORD_WIDTH-1:0] cen_x, cen_y, cen_z;
   logic [2*COORD_WIDTH-1:0]      sq_x, sq_y, sq_z;
   logic [COORD_WIDTH-1:0]        root;

   assign req_if.ready = (state_ff == ST_STREAM);
   assign take         = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign load_out     = (state_ff == ST_ROOT) && root_status.done && !root_status.busy
                         && out_free;
   assign root_start   = (state_ff == ST_START);

   assign lane_ctrl.take = take;
   assign lane_ctrl.seed = first_ff;

   mbbs_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .coord   ($signed(req_if.data.pos_x[COORD_WIDTH-1:0])),
      .box_min (min_x),
      .box_max (max_x),
      .centre  (cen_x),
      .square  (sq_x)
   );

   mbbs_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .coord   ($signed(req_if.data.pos_y[COORD_WIDTH-1:0])),
      .box_min (min_y),
      .box_max (max_y),
      .centre  (cen_y),
      .square  (sq_y)
   );

   mbbs_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .coord   ($signed(req_if.data.pos_z[COORD_WIDTH-1:0])),
      .box_min (min_z),
      .box_max (max_z),
      .centre  (cen_z),
      .square  (sq_z)
   );

   mbbs_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .square_x (sq_x),
      .square_y (sq_y),
      .square_z (sq_z),
      .status   (root_status),
      .radius   (root)
   );

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_STREAM: begin
            if (take) begin
               first_in = req_if.data.last_vertex;
               if (req_if.data.last_vertex) begin
                  state_in = ST_EXTENT;
               end
            end
         end
         ST_EXTENT: state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_START;
         ST_START:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (load_out) begin
               state_in             = ST_STREAM;
               rsp_valid_in         = 1'b1;
               rsp_data_in.min_x    = FW'(min_x);
               rsp_data_in.min_y    = FW'(min_y);
               rsp_data_in.min_z    = FW'(min_z);
               rsp_data_in.max_x    = FW'(max_x);
               rsp_data_in.max_y    = FW'(max_y);
               rsp_data_in.max_z    = FW'(max_z);
               rsp_data_in.centre_x = FW'(cen_x);
               rsp_data_in.centre_y = FW'(cen_y);
               rsp_data_in.centre_z = FW'(cen_z);
               rsp_data_in.radius   = FW'(root);
            end
         end
         default: state_in = ST_STREAM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_STREAM;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

@@ hdl/mbbs_checker.sv @@
module mbbs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mbbs_pkg::result_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.min_x <= rsp_data.centre_x) && (rsp_data.centre_x <= rsp_data.max_x) &&
         (rsp_data.min_y <= rsp_data.centre_y) && (rsp_data.centre_y <= rsp_data.max_y) &&
         (rsp_data.min_z <= rsp_data.centre_z) && (rsp_data.centre_z <= rsp_data.max_z))
      else $error("centre outside box");

   a_mesh_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("vertex taken while radius pending");

endmodule

bind mesh_bounding_box_sphere_unit mbbs_checker u_mbbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_last  (req_if.data.last_vertex),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
